// ----- hdl/shared_ring_packet_writer_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the shared ring packet writer
// Same-cycle and next-cycle implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHARED_RING_PACKET_WRITER_UNIT_MACROS_SVH
`define SHARED_RING_PACKET_WRITER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SRPW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SRPW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/srpw_pkg.sv -----
// ----------------------------------------------------------------------------
// srpw_pkg
// Types, codes and constants of the shared ring packet writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srpw_pkg;

    localparam int RING_BYTES_DEF  = 4096;
    localparam int MIN_RING        = 16;
    localparam int TRAILER_BYTES   = 8;
    localparam int TRAILER_SHIFT   = 32;
    localparam int TRL_CNT_W       = $clog2(TRAILER_BYTES);
    localparam int IDX_W           = 12;
    localparam int LEN_W           = 12;
    localparam int BYTE_W          = 8;
    localparam int RING_SIZE_W     = 13;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic [RING_SIZE_W-1:0] RING_SIZE_RESET = 13'd4096;

    // register index (paddr[2])
    localparam logic REG_RING_SIZE = 1'b0;

    localparam logic [2:0] OP_BEGIN    = 3'd0;
    localparam logic [2:0] OP_BYTE     = 3'd1;
    localparam logic [2:0] OP_CONSUMER = 3'd2;
    localparam logic [2:0] OP_MASK     = 3'd3;
    localparam logic [2:0] OP_READ     = 3'd4;

    localparam logic [1:0] KIND_REFUSED = 2'd0;
    localparam logic [1:0] KIND_COMMIT  = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  payload_len;
        logic [IDX_W-1:0]  index_value;
        logic              mask_value;
    } item_t;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic              need_signal;
        logic [IDX_W-1:0]  write_index;
        logic [BYTE_W-1:0] read_data;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TRAILER,
        ST_RDWAIT
    } srpw_state_t;

endpackage

`default_nettype wire

// ----- hdl/shared_ring_packet_writer_unit.sv -----
// ----------------------------------------------------------------------------
// shared_ring_packet_writer_unit
// Producer side of a byte ring shared with a consumer: space check, payload
// store, trailer store and commit, consumer index/mask, ring byte readback.
//
//   Channel   Direction  Handshake              Payload
//   item      in         item_valid/ready       srpw_pkg::item_t
//   result    out        result_valid/ready     srpw_pkg::result_t
//   config    in         APB psel/penable       ring_size at address 0
//
// The last payload byte (or an empty begin) is followed by the trailer state:
// the trailer bytes go one per cycle through the ring memory's single write
// port, the last one only together with the commit, which needs result space.
// A ring byte read waits in ST_RDWAIT for the memory's registered read data.
// No clearing pass after reset; the ring memory is not initialized.
// A full result skid entry stalls item acceptance, commit and read results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shared_ring_packet_writer_unit #(
    parameter int RING_BYTES = srpw_pkg::RING_BYTES_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 item_valid,
    output logic                                item_ready,
    input  wire srpw_pkg::item_t                item,
    output logic                                result_valid,
    input  wire                                 result_ready,
    output srpw_pkg::result_t                   result,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [srpw_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire [srpw_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [srpw_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    import srpw_pkg::*;

    localparam int AW = $clog2(RING_BYTES);
    localparam int SW = AW + 1;
    localparam int CW = (SW > RING_SIZE_W) ? SW : RING_SIZE_W;

    srpw_state_t state_reg, state_next;

    logic [RING_SIZE_W-1:0] ring_size_reg, ring_size_next;
    logic [AW-1:0]          committed_reg, committed_next;
    logic [AW-1:0]          working_reg, working_next;
    logic [AW-1:0]          start_reg, start_next;
    logic [LEN_W-1:0]       remaining_reg, remaining_next;
    logic                   open_reg, open_next;
    logic [AW-1:0]          consumer_reg, consumer_next;
    logic                   mask_reg, mask_next;
    logic [TRL_CNT_W-1:0]   cnt_reg, cnt_next;

    logic              item_fire;
    logic              cfg_write;
    logic              res_valid;
    logic              res_space;
    result_t           res;

    logic [CW-1:0]     rs_x;
    logic [CW-1:0]     eff_x;
    logic [SW-1:0]     eff;
    logic [CW-1:0]     idx_x;
    logic [CW-1:0]     com_x;
    logic [CW-1:0]     con_x;
    logic [CW-1:0]     avail;
    logic              refuse;
    logic [SW-1:0]     w_inc;
    logic [AW-1:0]     adv;
    logic [63:0]       trailer_word;
    logic              need;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;

    srpw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_BYTES)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    srpw_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (res_space),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_data  (result)
    );

    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && (paddr[2] == REG_RING_SIZE);
    assign prdata     = (paddr[2] == REG_RING_SIZE) ? APB_DATA_W'(ring_size_reg) : '0;

    assign item_ready = (state_reg == ST_IDLE) && res_space;
    assign item_fire  = item_valid && item_ready;

    // effective size, clamped to [MIN_RING, RING_BYTES]
    assign rs_x  = CW'(ring_size_reg);
    assign eff_x = (rs_x < CW'(MIN_RING))   ? CW'(MIN_RING)   :
                   (rs_x > CW'(RING_BYTES)) ? CW'(RING_BYTES) : rs_x;
    assign eff   = SW'(eff_x);

    assign idx_x  = CW'(item.index_value);
    assign com_x  = CW'(committed_reg);
    assign con_x  = CW'(consumer_reg);
    assign avail  = (com_x >= con_x) ? (CW'(eff) - (com_x - con_x)) : (con_x - com_x);
    assign refuse = avail <= (CW'(item.payload_len) + CW'(TRAILER_BYTES));

    assign w_inc = SW'(working_reg) + SW'(1);
    assign adv   = (w_inc >= eff) ? '0 : AW'(w_inc);

    assign trailer_word = 64'(start_reg) << TRAILER_SHIFT;
    assign need         = !mask_reg && (start_reg == consumer_reg);

    always_comb
    begin
        state_next     = state_reg;
        ring_size_next = ring_size_reg;
        committed_next = committed_reg;
        working_next   = working_reg;
        start_next     = start_reg;
        remaining_next = remaining_reg;
        open_next      = open_reg;
        consumer_next  = consumer_reg;
        mask_next      = mask_reg;
        cnt_next       = cnt_reg;

        mem_we    = 1'b0;
        mem_waddr = working_reg;
        mem_wdata = item.data_byte;
        mem_re    = 1'b0;
        mem_raddr = AW'(idx_x);

        res_valid       = 1'b0;
        res.result_kind = KIND_REFUSED;
        res.need_signal = 1'b0;
        res.write_index = IDX_W'(committed_reg);
        res.read_data   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    case (item.opcode)
                        OP_BEGIN:
                        begin
                            open_next      = 1'b0;
                            remaining_next = '0;
                            if (refuse)
                            begin
                                res_valid = 1'b1;
                            end
                            else
                            begin
                                open_next      = 1'b1;
                                start_next     = committed_reg;
                                working_next   = committed_reg;
                                remaining_next = item.payload_len;
                                if (item.payload_len == '0)
                                begin
                                    cnt_next   = '0;
                                    state_next = ST_TRAILER;
                                end
                            end
                        end
                        OP_BYTE:
                        begin
                            if (open_reg)
                            begin
                                mem_we         = 1'b1;
                                working_next   = adv;
                                remaining_next = remaining_reg - LEN_W'(1);
                                if (remaining_reg == LEN_W'(1))
                                begin
                                    cnt_next   = '0;
                                    state_next = ST_TRAILER;
                                end
                            end
                        end
                        OP_CONSUMER:
                        begin
                            if (idx_x < CW'(eff))
                            begin
                                consumer_next = AW'(idx_x);
                            end
                        end
                        OP_MASK:
                        begin
                            mask_next = item.mask_value;
                        end
                        OP_READ:
                        begin
                            if (idx_x < CW'(RING_BYTES))
                            begin
                                mem_re     = 1'b1;
                                state_next = ST_RDWAIT;
                            end
                            else
                            begin
                                res_valid       = 1'b1;
                                res.result_kind = KIND_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TRAILER:
            begin
                mem_wdata = trailer_word[{cnt_reg, 3'b000} +: BYTE_W];
                if (cnt_reg != TRL_CNT_W'(TRAILER_BYTES - 1))
                begin
                    mem_we       = 1'b1;
                    working_next = adv;
                    cnt_next     = cnt_reg + TRL_CNT_W'(1);
                end
                else if (res_space)
                begin
                    mem_we          = 1'b1;
                    working_next    = adv;
                    committed_next  = adv;
                    open_next       = 1'b0;
                    remaining_next  = '0;
                    res_valid       = 1'b1;
                    res.result_kind = KIND_COMMIT;
                    res.need_signal = need;
                    res.write_index = IDX_W'(adv);
                    state_next      = ST_IDLE;
                end
            end
            ST_RDWAIT:
            begin
                if (res_space)
                begin
                    res_valid       = 1'b1;
                    res.result_kind = KIND_READ;
                    res.read_data   = mem_rdata;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // ring restarts empty, mask kept
        if (cfg_write)
        begin
            ring_size_next = pwdata[RING_SIZE_W-1:0];
            committed_next = '0;
            working_next   = '0;
            start_next     = '0;
            remaining_next = '0;
            open_next      = 1'b0;
            consumer_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ring_size_reg <= RING_SIZE_RESET;
            committed_reg <= '0;
            working_reg   <= '0;
            start_reg     <= '0;
            remaining_reg <= '0;
            open_reg      <= 1'b0;
            consumer_reg  <= '0;
            mask_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ring_size_reg <= ring_size_next;
            committed_reg <= committed_next;
            working_reg   <= working_next;
            start_reg     <= start_next;
            remaining_reg <= remaining_next;
            open_reg      <= open_next;
            consumer_reg  <= consumer_next;
            mask_reg      <= mask_next;
            cnt_reg       <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/srpw_ram.sv -----
// ----------------------------------------------------------------------------
// srpw_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire                     re,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/srpw_out_stage.sv -----
// ----------------------------------------------------------------------------
// srpw_out_stage
// Result output register with a skid entry behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srpw_out_stage (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push,
    input  wire srpw_pkg::result_t push_data,
    output logic                   space,
    output logic                   out_valid,
    input  wire                    out_ready,
    output srpw_pkg::result_t      out_data
);

    import srpw_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    // push only arrives while the skid entry is empty
    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

// ----- hdl/srpw_checker.sv -----
// ----------------------------------------------------------------------------
// srpw_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "shared_ring_packet_writer_unit_macros.svh"

module srpw_checker (
    input wire                    clk,
    input wire                    rst_n,
    input wire                    result_valid,
    input wire                    result_ready,
    input wire srpw_pkg::result_t result
);

    import srpw_pkg::*;

    `SRPW_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(result), "stalled result transfer changed")
    `SRPW_ASSERT_NOW(a_signal_on_commit, result_valid && (result.result_kind != KIND_COMMIT),
        !result.need_signal, "need_signal outside a commit")
    `SRPW_ASSERT_NOW(a_data_on_read, result_valid && (result.result_kind != KIND_READ),
        result.read_data == '0, "read_data outside a read")

endmodule

bind shared_ring_packet_writer_unit srpw_checker u_srpw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
